[src/madfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madfd_pkg
// shared types and constants of the multi-lane converter frame deserializer
// ----------------------------------------------------------------------------
package madfd_pkg;

    localparam int unsigned IN_LANES     = 8;
    localparam int unsigned RAW_W        = 32;
    localparam int unsigned TOP_BITS     = 20;
    localparam int unsigned STATUS_BITS  = 8;
    localparam int unsigned SIZE_W       = 6;
    localparam int unsigned TOP_SHIFT_W  = 4;
    localparam int unsigned PKT_W        = 4;

    localparam logic       KIND_START = 1'b0;
    localparam logic       KIND_TICK  = 1'b1;

    localparam logic [1:0] MODE_20 = 2'd0;
    localparam logic [1:0] MODE_24 = 2'd1;
    localparam logic [1:0] MODE_32 = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_20 = 6'd20;
    localparam logic [SIZE_W-1:0] SIZE_24 = 6'd24;
    localparam logic [SIZE_W-1:0] SIZE_32 = 6'd32;

    localparam logic [PKT_W-1:0] CHANNEL_PACKETS = 4'd8;

    typedef struct packed {
        logic                kind;
        logic [IN_LANES-1:0] lane_bits;
    } item_t;

    typedef struct packed {
        logic [PKT_W-1:0]           packet_index;
        logic [RAW_W-1:0]           raw_value;
        logic signed [TOP_BITS-1:0] result_signed;
        logic                       is_status;
        logic                       frame_done;
    } result_t;

    typedef struct packed {
        logic                   push;
        logic [PKT_W-1:0]       packet_number;
        logic [TOP_SHIFT_W-1:0] top_shift;
    } pkt_ctrl_t;

endpackage

[src/madfd_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madfd_lane
// one data lane: shift register taking one serial bit per tick
// ----------------------------------------------------------------------------
module madfd_lane #(
    parameter int unsigned WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  logic             clear,
    input  logic             data_bit,
    output logic [WIDTH-1:0] shift_next
);

    logic [WIDTH-1:0] shift_reg;

    assign shift_next = {shift_reg[WIDTH-2:0], data_bit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
        end
        else if (clear)
        begin
            shift_reg <= '0;
        end
        else if (shift_en)
        begin
            shift_reg <= shift_next;
        end
    end

endmodule

[src/madfd_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madfd_merge
// picks the lane of the finished packet, forms the result word and holds it
// in a two-entry output queue
// ----------------------------------------------------------------------------
module madfd_merge import madfd_pkg::*; #(
    parameter int unsigned LANES  = 8,
    parameter int unsigned LANE_W = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pkt_ctrl_t                     ctrl,
    input  logic [LANES-1:0][LANE_W-1:0]  lane_next,
    output result_t                       result,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          full
);

    logic [LANE_W-1:0] lane_sel;
    logic [RAW_W-1:0]  raw_chan;
    logic [RAW_W-1:0]  top_word;
    result_t           word_new;
    result_t           head_reg;
    result_t           head_next;
    result_t           skid_reg;
    result_t           skid_next;
    logic              head_valid_reg;
    logic              head_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic              pop;

    // lane mux
    always_comb
    begin
        lane_sel = '0;
        for (int k = 0; k < LANES; k++)
        begin
            if (PKT_W'(k) == ctrl.packet_number)
            begin
                lane_sel = lane_next[k];
            end
        end
    end

    assign raw_chan = RAW_W'(lane_sel);
    assign top_word = raw_chan >> ctrl.top_shift;

    always_comb
    begin
        word_new.packet_index = ctrl.packet_number;
        if (ctrl.packet_number < CHANNEL_PACKETS)
        begin
            word_new.raw_value     = raw_chan;
            word_new.result_signed = $signed(top_word[TOP_BITS-1:0]);
            word_new.is_status     = 1'b0;
            word_new.frame_done    = 1'b0;
        end
        else
        begin
            word_new.packet_index  = CHANNEL_PACKETS;
            word_new.raw_value     = RAW_W'(lane_next[0][STATUS_BITS-1:0]);
            word_new.result_signed = '0;
            word_new.is_status     = 1'b1;
            word_new.frame_done    = 1'b1;
        end
    end

    // output queue
    assign pop = head_valid_reg && !result_stall;

    always_comb
    begin
        head_next       = head_reg;
        skid_next       = skid_reg;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                head_valid_next = 1'b0;
            end
        end
        if (ctrl.push)
        begin
            if (!head_valid_next)
            begin
                head_next       = word_new;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = word_new;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign result       = head_reg;
    assign result_valid = head_valid_reg;
    assign full         = skid_valid_reg;

endmodule

[src/multilane_adc_frame_deserializer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilane_adc_frame_deserializer
// frame receiver for a converter shifting results out on parallel data lanes
// ----------------------------------------------------------------------------
// Takes one input word every clock cycle unless stalled: a start word arms a
// frame, each tick word in a frame shifts one bit into every lane register in
// the same cycle. A completing tick pushes its result word into a two-entry
// output queue behind the lane mux, whose head register drives the output;
// the input only stalls while two result words wait on the downstream side.
// ----------------------------------------------------------------------------
module multilane_adc_frame_deserializer import madfd_pkg::*; #(
    parameter int unsigned LANES           = 8,
    parameter int unsigned MAX_PACKET_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);

    localparam int unsigned LANE_W = MAX_PACKET_BITS;
    localparam int unsigned CNT_W  = $clog2(MAX_PACKET_BITS);
    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_PACKET_BITS);

    logic [1:0]                   mode_reg;
    logic [CNT_W-1:0]             bit_in_packet_reg;
    logic [CNT_W-1:0]             bit_in_packet_next;
    logic [PKT_W-1:0]             packet_number_reg;
    logic [PKT_W-1:0]             packet_number_next;
    logic                         receiving_reg;
    logic                         receiving_next;
    logic [SIZE_W-1:0]            size_mode;
    logic [SIZE_W-1:0]            size;
    logic [CNT_W:0]               count;
    logic                         accept;
    logic                         start;
    logic                         tick;
    logic                         complete;
    logic                         channel;
    logic                         queue_full;
    pkt_ctrl_t                    ctrl;
    logic [LANES-1:0][LANE_W-1:0] lane_next;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_20;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= cfg_data;
        end
    end

    always_comb
    begin
        case (mode_reg)
            MODE_20: size_mode = SIZE_20;
            MODE_24: size_mode = SIZE_24;
            MODE_32: size_mode = SIZE_32;
            default: size_mode = SIZE_32;
        endcase
        size = size_mode;
        if (size > MAX_SIZE)
        begin
            size = MAX_SIZE;
        end
        if (size < SIZE_20)
        begin
            size = SIZE_20;
        end
    end

    // frame control
    assign item_stall = queue_full;
    assign accept     = item_valid && !item_stall;
    assign start      = accept && (item.kind == KIND_START);
    assign tick       = accept && (item.kind == KIND_TICK) && receiving_reg;
    assign count      = {1'b0, bit_in_packet_reg} + (CNT_W + 1)'(1);
    assign complete   = tick && (SIZE_W'(count) >= size);
    assign channel    = packet_number_reg < CHANNEL_PACKETS;

    always_comb
    begin
        bit_in_packet_next = bit_in_packet_reg;
        packet_number_next = packet_number_reg;
        receiving_next     = receiving_reg;
        if (start)
        begin
            bit_in_packet_next = '0;
            packet_number_next = '0;
            receiving_next     = 1'b1;
        end
        else if (complete)
        begin
            bit_in_packet_next = '0;
            if (channel)
            begin
                packet_number_next = packet_number_reg + PKT_W'(1);
            end
            else
            begin
                packet_number_next = '0;
                receiving_next     = 1'b0;
            end
        end
        else if (tick)
        begin
            bit_in_packet_next = count[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_in_packet_reg <= '0;
            packet_number_reg <= '0;
            receiving_reg     <= 1'b0;
        end
        else
        begin
            bit_in_packet_reg <= bit_in_packet_next;
            packet_number_reg <= packet_number_next;
            receiving_reg     <= receiving_next;
        end
    end

    // lanes
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        logic data_bit;
        if (k < IN_LANES)
        begin : g_in
            assign data_bit = item.lane_bits[k];
        end
        else
        begin : g_zero
            assign data_bit = 1'b0;
        end
        madfd_lane #(
            .WIDTH (LANE_W)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (tick),
            .clear      (start || complete),
            .data_bit   (data_bit),
            .shift_next (lane_next[k])
        );
    end

    // merge
    assign ctrl.push          = complete;
    assign ctrl.packet_number = packet_number_reg;
    assign ctrl.top_shift     = TOP_SHIFT_W'(size - SIZE_20);

    madfd_merge #(
        .LANES  (LANES),
        .LANE_W (LANE_W)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .lane_next    (lane_next),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .full         (queue_full)
    );

    // checks
    a_pkt_range: assert property (@(posedge clk) disable iff (!rst_n)
        packet_number_reg <= CHANNEL_PACKETS)
        else $error("packet number out of range");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !receiving_reg |-> (packet_number_reg == '0 && bit_in_packet_reg == '0))
        else $error("counters not clear while idle");

    a_status_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (complete && !channel && !start) |=> !receiving_reg)
        else $error("frame not closed after status packet");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        complete |-> !queue_full)
        else $error("result pushed into full queue");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the multi-lane converter frame deserializer
// ----------------------------------------------------------------------------
// Drives start and tick words with random gaps and random downstream stalls,
// predicts every packet and status word in a behavioral lane model, and
// compares each accepted result word field by field. Covers every packet
// size setting, ticks outside a frame, restarts, size changes inside a
// packet and a long downstream hold that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
    import madfd_pkg::*;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         IDLE_LIMIT  = 3000;
    localparam int         DRAIN_WAIT  = 4;
    localparam int         RANDOM_WORDS = 1600;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    item_t      item_word;
    logic       result_valid;
    logic       result_stall;
    result_t    result_word;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;

    logic [RAW_W-1:0] lane_reg [IN_LANES];
    int unsigned      bit_count;
    logic [PKT_W-1:0] pkt_num;
    logic             armed;
    logic [1:0]       size_mode;

    result_t pending_results [$];
    int      error_count;
    int      word_count;
    int      hold_left;
    bit      calm;

    multilane_adc_frame_deserializer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned packet_len();
        case (size_mode)
            MODE_20: return int'(SIZE_20);
            MODE_24: return int'(SIZE_24);
            default: return int'(SIZE_32);
        endcase
    endfunction

    task automatic clear_lanes();
        for (int k = 0; k < IN_LANES; k++)
            lane_reg[k] = '0;
        bit_count = 0;
    endtask

    // lane model: shift, count, emit on packet completion
    task automatic track_word(input item_t w);
        result_t     r;
        int unsigned len;
        int unsigned cnt;
        logic [RAW_W-1:0] raw;
        if (w.kind == KIND_START)
        begin
            clear_lanes();
            pkt_num = '0;
            armed = 1'b1;
            return;
        end
        if (!armed)
            return;
        for (int k = 0; k < IN_LANES; k++)
            lane_reg[k] = {lane_reg[k][RAW_W-2:0], w.lane_bits[k]};
        len = packet_len();
        cnt = bit_count + 1;
        if (cnt < len)
        begin
            bit_count = cnt & 31;
            return;
        end
        if (pkt_num < CHANNEL_PACKETS)
        begin
            raw = lane_reg[pkt_num[2:0]];
            r.packet_index = pkt_num;
            r.raw_value = raw;
            r.result_signed = TOP_BITS'(raw >> (len - TOP_BITS));
            r.is_status = 1'b0;
            r.frame_done = 1'b0;
            pkt_num = pkt_num + 1'b1;
        end
        else
        begin
            r.packet_index = CHANNEL_PACKETS;
            r.raw_value = {{(RAW_W-STATUS_BITS){1'b0}}, lane_reg[0][STATUS_BITS-1:0]};
            r.result_signed = '0;
            r.is_status = 1'b1;
            r.frame_done = 1'b1;
            pkt_num = '0;
            armed = 1'b0;
        end
        clear_lanes();
        pending_results.push_back(r);
    endtask

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    task automatic send_word(input item_t w);
        bit taken;
        int gap;
        item_valid <= 1'b1;
        item_word <= w;
        do
        begin
            @(negedge clk);
            taken = !item_stall;
            @(posedge clk);
        end
        while (!taken);
        word_count++;
        track_word(w);
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_start();
        item_t w;
        w.kind = KIND_START;
        w.lane_bits = IN_LANES'($urandom);
        send_word(w);
    endtask

    task automatic send_tick(input logic [IN_LANES-1:0] bits);
        item_t w;
        w.kind = KIND_TICK;
        w.lane_bits = bits;
        send_word(w);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_size_mode(input logic [1:0] mode);
        bit taken;
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        size_mode = mode;
    endtask

    function automatic logic [IN_LANES-1:0] pattern_bits(input int style, input int n);
        case (style)
            1: return '1;
            2: return '0;
            3: return n[0] ? 8'hAA : 8'h55;
            default: return IN_LANES'($urandom);
        endcase
    endfunction

    // start, then ticks until the status word closes the frame
    task automatic run_frame(input int style, input int switch_at, input logic [1:0] new_mode);
        int n;
        n = 0;
        send_start();
        while (armed)
        begin
            if (n == switch_at)
                write_size_mode(new_mode);
            send_tick(pattern_bits(style, n));
            n++;
        end
    endtask

    task automatic test_idle_ticks();
        send_tick('1);
        send_tick('0);
        send_tick(8'h5A);
    endtask

    task automatic test_restart();
        send_start();
        repeat (7) send_tick('1);
        send_start();
        repeat (3) send_tick(8'hA5);
    endtask

    task automatic test_size_change();
        write_size_mode(MODE_32);
        send_start();
        repeat (22) send_tick(IN_LANES'($urandom));
        write_size_mode(MODE_20);
        send_tick(IN_LANES'($urandom));
        send_tick(IN_LANES'($urandom));
    endtask

    task automatic test_size_modes();
        logic [1:0] order [4];
        order = '{MODE_SPARE, MODE_20, MODE_24, MODE_32};
        for (int i = 0; i < 4; i++)
        begin
            write_size_mode(order[i]);
            run_frame(i, -1, MODE_20);
        end
    endtask

    task automatic test_backpressure();
        write_size_mode(MODE_20);
        calm = 1'b1;
        hold_left = 160;
        run_frame(0, -1, MODE_20);
        calm = 1'b0;
    endtask

    task automatic test_random_traffic();
        int    r;
        item_t w;
        while (word_count < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 4) == 0)
                calm = !calm;
            r = $urandom_range(0, 19);
            if (r < 12)
                run_frame($urandom_range(0, 3), -1, MODE_20);
            else if (r < 14)
                run_frame(0, $urandom_range(1, 150), 2'($urandom_range(0, 3)));
            else if (r < 16)
            begin
                send_start();
                repeat ($urandom_range(1, 120)) send_tick(IN_LANES'($urandom));
            end
            else if (r < 18)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    w.kind = 1'($urandom_range(0, 1));
                    w.lane_bits = IN_LANES'($urandom);
                    send_word(w);
                end
            end
            else
                write_size_mode(2'($urandom_range(0, 3)));
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item_word = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        error_count = 0;
        word_count = 0;
        hold_left = 0;
        calm = 1'b0;
        size_mode = MODE_20;
        pkt_num = '0;
        armed = 1'b0;
        clear_lanes();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_ticks();
        test_restart();
        test_size_change();
        test_size_modes();
        test_backpressure();
        test_random_traffic();

        drain();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("multilane_adc_frame_deserializer verification clean");
        else
            $display("multilane_adc_frame_deserializer verification failed");
        $finish;
    end

    // downstream side: random stalls plus the long hold
    initial
    begin
        int stall_run;
        stall_run = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_run > 0)
            begin
                result_stall <= 1'b1;
                stall_run--;
            end
            else if (!calm && $urandom_range(0, 99) < 30)
            begin
                result_stall <= 1'b1;
                stall_run = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                         : $urandom_range(9, 29);
            end
            else
                result_stall <= 1'b0;
        end
    end

    // result word check against the oldest prediction
    initial
    begin
        result_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result word, packet_index %0d",
                           result_word.packet_index);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result_word.packet_index !== want.packet_index)
                    begin
                        $error("packet_index expected %0d got %0d",
                               want.packet_index, result_word.packet_index);
                        error_count++;
                    end
                    if (result_word.raw_value !== want.raw_value)
                    begin
                        $error("raw_value expected %h got %h",
                               want.raw_value, result_word.raw_value);
                        error_count++;
                    end
                    if (result_word.result_signed !== want.result_signed)
                    begin
                        $error("result_signed expected %0d got %0d",
                               want.result_signed, result_word.result_signed);
                        error_count++;
                    end
                    if (result_word.is_status !== want.is_status)
                    begin
                        $error("is_status expected %0b got %0b",
                               want.is_status, result_word.is_status);
                        error_count++;
                    end
                    if (result_word.frame_done !== want.frame_done)
                    begin
                        $error("frame_done expected %0b got %0b",
                               want.frame_done, result_word.frame_done);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(negedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("multilane_adc_frame_deserializer verification failed");
        $finish;
    end

endmodule
